>>> rtl/grid_nearest_point_lookup_assert.svh
// Assertion macros for the grid nearest point lookup.
// Used by the top level; expects clk and arst_n in scope.
`ifndef GRID_NEAREST_POINT_LOOKUP_ASSERT_SVH
`define GRID_NEAREST_POINT_LOOKUP_ASSERT_SVH

// Property checked on every clock edge outside reset
`define GNPL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication checked on the following edge
`define GNPL_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) else $error(msg);

`endif

>>> rtl/gnpl_pkg.sv
// Shared types and constants for the grid nearest point lookup.
// No dependencies.
`default_nettype none

package gnpl_pkg;

	localparam int MAX_POINTS    = 1024;
	localparam int PT_AW         = $clog2(MAX_POINTS);
	localparam int MAX_GRID_SIDE = 32;
	localparam int CELL_AW       = $clog2(MAX_GRID_SIDE * MAX_GRID_SIDE);
	localparam int Q_DEPTH       = 4;
	localparam int Q_AW          = $clog2(Q_DEPTH);

	// item kinds; the fourth code is dropped at the front
	localparam logic [1:0] KIND_CLEAR  = 2'd0;
	localparam logic [1:0] KIND_LOAD   = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;
	localparam logic [1:0] KIND_IGNORE = 2'd3;

	typedef struct packed {
		logic        water;
		logic [15:0] elev;
		logic [15:0] pos_y;
		logic [15:0] pos_x;
		logic [1:0]  kind;
	} item_t;

	typedef struct packed {
		logic clearing;
	} eng_stat_t;

endpackage

`default_nettype wire

>>> rtl/gnpl_front.sv
// Front part: accepts items, drops unknown kinds, queues the rest.
// Depends on gnpl_pkg.
`default_nettype none

module gnpl_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire gnpl_pkg::item_t in_item,
	output logic                 q_valid,
	output gnpl_pkg::item_t      q_item,
	input  wire logic            q_pop,
	output logic [gnpl_pkg::Q_AW:0] q_count
);

	gnpl_pkg::item_t             fifo_q [gnpl_pkg::Q_DEPTH];
	logic [gnpl_pkg::Q_AW-1:0]   wr_q, rd_q;
	logic [gnpl_pkg::Q_AW:0]     cnt_q;
	logic                        push, pop, known;

	// classify: only clear, load and query enter the queue
	assign known = (in_item.kind == gnpl_pkg::KIND_CLEAR) ||
	               (in_item.kind == gnpl_pkg::KIND_LOAD) ||
	               (in_item.kind == gnpl_pkg::KIND_QUERY);
	assign in_ready = (cnt_q != (gnpl_pkg::Q_AW+1)'(gnpl_pkg::Q_DEPTH));
	assign push     = in_valid && in_ready && known;
	assign pop      = q_pop && (cnt_q != '0);
	assign q_valid  = (cnt_q != '0);
	assign q_item   = fifo_q[rd_q];
	assign q_count  = cnt_q;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= in_item;
		end
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> rtl/gnpl_engine.sv
// Back part: point store, bucket grid and the nearest point search.
// Depends on gnpl_pkg.
`default_nettype none

module gnpl_engine (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [5:0]      side,
	input  wire logic            q_valid,
	input  wire gnpl_pkg::item_t q_item,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [9:0]           out_index,
	output logic [15:0]          out_elev,
	output logic                 out_water,
	output logic                 out_none,
	output gnpl_pkg::eng_stat_t  stat
);

	typedef enum logic [11:0] {
		S_CLR     = 12'b000000000001,
		S_IDLE    = 12'b000000000010,
		S_GRID    = 12'b000000000100,
		S_LD_RD   = 12'b000000001000,
		S_LD_WR   = 12'b000000010000,
		S_Q_CELL  = 12'b000000100000,
		S_Q_BWAIT = 12'b000001000000,
		S_PWAIT   = 12'b000010000000,
		S_MUL     = 12'b000100000000,
		S_CMP     = 12'b001000000000,
		S_FB      = 12'b010000000000,
		S_OUT     = 12'b100000000000
	} state_t;

	localparam int PW = gnpl_pkg::PT_AW;
	localparam int CW = gnpl_pkg::CELL_AW;

	state_t          state_q;
	gnpl_pkg::item_t item_q;
	logic [CW-1:0]   clr_q, cell_q;
	logic [PW:0]     count_q;
	logic [4:0]      gx_q, gy_q;
	logic [3:0]      nb_q;
	logic            fb_q, found_q, none_q;
	logic [PW-1:0]   fbi_q, cand_q, best_idx_q;
	logic [15:0]     cand_elev_q, best_elev_q;
	logic            cand_water_q, best_water_q;
	logic [32:0]     best_q;
	logic signed [16:0] dx_q, dy_q;
	logic signed [33:0] dx_w, dy_w;
	logic [31:0]     sqx_q, sqy_q;
	logic            out_valid_q, out_water_q, out_none_q;
	logic [9:0]      out_index_q;
	logic [15:0]     out_elev_q;
	logic            out_fire;

	// memories
	logic [PW:0]     bmem [1 << CW];
	logic [48:0]     pmem [1 << PW];
	logic [PW:0]     brd_q;
	logic [48:0]     prd_q;
	logic            b_we, p_we;
	logic [CW-1:0]   b_waddr, b_raddr;
	logic [PW:0]     b_wdata;
	logic [PW-1:0]   p_raddr;

	logic [5:0]      side_e;
	logic [21:0]     prod_x, prod_y;
	logic [5:0]      gx_raw, gy_raw;
	logic [CW-1:0]   cell_calc, ncell;
	logic signed [6:0] offx, offy, nx, ny;
	logic            in_grid, last_nb;
	logic [32:0]     dist_sum;
	logic            better;

	// side clamped to 1..MAX_GRID_SIDE
	always_comb begin
		side_e = side;
		if (side == 6'd0) side_e = 6'd1;
		else if (side > 6'(gnpl_pkg::MAX_GRID_SIDE)) side_e = 6'(gnpl_pkg::MAX_GRID_SIDE);
	end

	// grid cell of the current item
	assign prod_x = 22'(item_q.pos_x) * 22'(side_e);
	assign prod_y = 22'(item_q.pos_y) * 22'(side_e);
	assign gx_raw = (prod_x[21:16] >= side_e) ? side_e - 6'd1 : prod_x[21:16];
	assign gy_raw = (prod_y[21:16] >= side_e) ? side_e - 6'd1 : prod_y[21:16];
	assign cell_calc = CW'(10'(gy_q) * 10'(side_e)) + CW'(gx_q);

	// neighbour offsets, dy outer, dx inner
	always_comb begin
		case (nb_q)
			4'd0: begin offy = -7'sd1; offx = -7'sd1; end
			4'd1: begin offy = -7'sd1; offx = 7'sd0; end
			4'd2: begin offy = -7'sd1; offx = 7'sd1; end
			4'd3: begin offy = 7'sd0; offx = -7'sd1; end
			4'd4: begin offy = 7'sd0; offx = 7'sd0; end
			4'd5: begin offy = 7'sd0; offx = 7'sd1; end
			4'd6: begin offy = 7'sd1; offx = -7'sd1; end
			4'd7: begin offy = 7'sd1; offx = 7'sd0; end
			4'd8: begin offy = 7'sd1; offx = 7'sd1; end
			default: begin offy = 7'sd0; offx = 7'sd0; end
		endcase
	end
	assign nx      = $signed({2'b00, gx_q}) + offx;
	assign ny      = $signed({2'b00, gy_q}) + offy;
	assign in_grid = !nx[6] && !ny[6] && (nx[5:0] < side_e) && (ny[5:0] < side_e);
	assign ncell   = CW'(10'(ny[4:0]) * 10'(side_e)) + CW'(nx[4:0]);
	assign last_nb = (nb_q == 4'd8);

	// differences widened before squaring
	assign dx_w = 34'(dx_q);
	assign dy_w = 34'(dy_q);

	// distance and strict less-than
	assign dist_sum = 33'(sqx_q) + 33'(sqy_q);
	assign better   = !found_q || (dist_sum < best_q);

	// memory port controls
	always_comb begin
		b_we    = 1'b0;
		b_waddr = clr_q;
		b_wdata = '0;
		if (state_q == S_CLR) begin
			b_we = 1'b1;
		end else if (state_q == S_LD_WR && !brd_q[PW]) begin
			b_we    = 1'b1;
			b_waddr = cell_q;
			b_wdata = {1'b1, count_q[PW-1:0]};
		end
		b_raddr = (state_q == S_LD_RD) ? cell_calc : ncell;
		p_we    = (state_q == S_LD_RD);
		p_raddr = (state_q == S_FB) ? fbi_q : brd_q[PW-1:0];
	end

	always_ff @(posedge clk) begin
		if (b_we) bmem[b_waddr] <= b_wdata;
		brd_q <= bmem[b_raddr];
	end

	always_ff @(posedge clk) begin
		if (p_we) pmem[count_q[PW-1:0]] <= {item_q.water, item_q.elev, item_q.pos_y, item_q.pos_x};
		prd_q <= pmem[p_raddr];
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;

	// result register loads when empty or being taken
	assign out_fire = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			item_q       <= '0;
			clr_q        <= '0;
			cell_q       <= '0;
			count_q      <= '0;
			gx_q         <= '0;
			gy_q         <= '0;
			nb_q         <= '0;
			fb_q         <= 1'b0;
			found_q      <= 1'b0;
			none_q       <= 1'b0;
			fbi_q        <= '0;
			cand_q       <= '0;
			cand_elev_q  <= '0;
			cand_water_q <= 1'b0;
			best_q       <= '0;
			best_idx_q   <= '0;
			best_elev_q  <= '0;
			best_water_q <= 1'b0;
			dx_q         <= '0;
			dy_q         <= '0;
			sqx_q        <= '0;
			sqy_q        <= '0;
			out_valid_q  <= 1'b0;
			out_index_q  <= '0;
			out_elev_q   <= '0;
			out_water_q  <= 1'b0;
			out_none_q   <= 1'b0;
		end else begin
			if (out_fire) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_valid) begin
						item_q  <= q_item;
						state_q <= S_GRID;
					end
				end
				S_GRID: begin
					gx_q <= gx_raw[4:0];
					gy_q <= gy_raw[4:0];
					case (item_q.kind)
						gnpl_pkg::KIND_CLEAR: begin
							count_q <= '0;
							clr_q   <= '0;
							state_q <= S_CLR;
						end
						gnpl_pkg::KIND_LOAD: begin
							if (count_q == (PW+1)'(gnpl_pkg::MAX_POINTS)) state_q <= S_IDLE;
							else state_q <= S_LD_RD;
						end
						default: begin
							nb_q    <= '0;
							fb_q    <= 1'b0;
							found_q <= 1'b0;
							if (count_q == '0) begin
								none_q       <= 1'b1;
								best_idx_q   <= '0;
								best_elev_q  <= '0;
								best_water_q <= 1'b0;
								state_q      <= S_OUT;
							end else begin
								none_q  <= 1'b0;
								state_q <= S_Q_CELL;
							end
						end
					endcase
				end
				S_LD_RD: begin
					cell_q  <= cell_calc;
					state_q <= S_LD_WR;
				end
				S_LD_WR: begin
					count_q <= count_q + 1'b1;
					state_q <= S_IDLE;
				end
				S_Q_CELL: begin
					if (in_grid) begin
						state_q <= S_Q_BWAIT;
					end else if (!last_nb) begin
						nb_q <= nb_q + 1'b1;
					end else if (found_q) begin
						state_q <= S_OUT;
					end else begin
						fb_q    <= 1'b1;
						fbi_q   <= '0;
						state_q <= S_FB;
					end
				end
				S_Q_BWAIT: begin
					if (brd_q[PW]) begin
						cand_q  <= brd_q[PW-1:0];
						state_q <= S_PWAIT;
					end else if (!last_nb) begin
						nb_q    <= nb_q + 1'b1;
						state_q <= S_Q_CELL;
					end else if (found_q) begin
						state_q <= S_OUT;
					end else begin
						fb_q    <= 1'b1;
						fbi_q   <= '0;
						state_q <= S_FB;
					end
				end
				S_FB: begin
					cand_q  <= fbi_q;
					state_q <= S_PWAIT;
				end
				S_PWAIT: begin
					dx_q         <= $signed({1'b0, prd_q[15:0]}) - $signed({1'b0, item_q.pos_x});
					dy_q         <= $signed({1'b0, prd_q[31:16]}) - $signed({1'b0, item_q.pos_y});
					cand_elev_q  <= prd_q[47:32];
					cand_water_q <= prd_q[48];
					state_q      <= S_MUL;
				end
				S_MUL: begin
					sqx_q   <= 32'(dx_w * dx_w);
					sqy_q   <= 32'(dy_w * dy_w);
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (better) begin
						found_q      <= 1'b1;
						best_q       <= dist_sum;
						best_idx_q   <= cand_q;
						best_elev_q  <= cand_elev_q;
						best_water_q <= cand_water_q;
					end
					if (fb_q) begin
						if ((PW+1)'(fbi_q) + 1'b1 == count_q) begin
							state_q <= S_OUT;
						end else begin
							fbi_q   <= fbi_q + 1'b1;
							state_q <= S_FB;
						end
					end else if (last_nb) begin
						state_q <= S_OUT;
					end else begin
						nb_q    <= nb_q + 1'b1;
						state_q <= S_Q_CELL;
					end
				end
				S_OUT: begin
					if (out_fire) begin
						out_index_q <= 10'(best_idx_q);
						out_elev_q  <= best_elev_q;
						out_water_q <= best_water_q;
						out_none_q  <= none_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign out_index     = out_index_q;
	assign out_elev      = out_elev_q;
	assign out_water     = out_water_q;
	assign out_none      = out_none_q;
	assign stat.clearing = (state_q == S_CLR);

endmodule

`default_nettype wire

>>> rtl/grid_nearest_point_lookup.sv
// Top level of the grid nearest point lookup: side register, front and back.
// Depends on gnpl_pkg, gnpl_front, gnpl_engine, grid_nearest_point_lookup_assert.svh.
//
// Channel  | Dir | Payload
// s_axis   | in  | tuser: kind; tdata: pos_x, pos_y, point_elevation, point_water
// m_axis   | out | tuser: no_points; tdata: nearest_index, nearest_elevation, nearest_water
// cfg      | in  | cfg_data: grid_side
//
// A query visits each neighbour cell in turn, reading the bucket memory and, for a
// non-empty cell, the point memory through their single read ports; cells outside
// the grid are skipped, and the full-store fallback reads every loaded point.
// A clear, and reset, sweep all 1024 bucket memory entries before items move.
// A four-item queue lets input be taken while a result waits for m_tready.
`default_nettype none
`include "grid_nearest_point_lookup_assert.svh"

module grid_nearest_point_lookup (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,   // pos_x, pos_y, point_elevation, point_water
	input  wire logic [1:0]  s_tuser,   // kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // nearest_index, nearest_elevation, nearest_water
	output logic             m_tuser,   // no_points
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [5:0]  cfg_data
);

	logic [5:0]                   side_q;
	gnpl_pkg::item_t              in_item, q_item;
	logic                         q_valid, q_pop;
	logic [gnpl_pkg::Q_AW:0]      q_count;
	logic [9:0]                   r_index;
	logic [15:0]                  r_elev;
	logic                         r_water;
	gnpl_pkg::eng_stat_t          stat;

	// grid side register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= 6'd1;
		end else if (cfg_valid && cfg_ready) begin
			side_q <= cfg_data;
		end
	end

	// unpack the input item
	assign in_item.kind  = s_tuser;
	assign in_item.pos_x = s_tdata[15:0];
	assign in_item.pos_y = s_tdata[31:16];
	assign in_item.elev  = s_tdata[47:32];
	assign in_item.water = s_tdata[48];

	gnpl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.q_count  (q_count)
	);

	gnpl_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.side      (side_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_index (r_index),
		.out_elev  (r_elev),
		.out_water (r_water),
		.out_none  (m_tuser),
		.stat      (stat)
	);

	// pack the result
	assign m_tdata = {5'b0, r_water, r_elev, r_index};

	// checks
	`GNPL_ASSERT(a_no_result_in_sweep, ($rose(m_tvalid) |-> !$past(stat.clearing)), "result during bucket sweep")
	`GNPL_ASSERT(a_queue_bound, (q_count <= (gnpl_pkg::Q_AW+1)'(gnpl_pkg::Q_DEPTH)), "queue overfilled")
	`GNPL_ASSERT_NEXT(a_drop_unknown, (s_tvalid && s_tready && s_tuser == gnpl_pkg::KIND_IGNORE && !q_pop), (q_count == $past(q_count)), "unknown kind queued")

endmodule

`default_nettype wire

>>> bench/grid_nearest_point_lookup_tb.sv
// Self-checking bench for grid_nearest_point_lookup: directed and random clears,
// loads and queries checked against an in-bench nearest-point predictor.
// Depends on gnpl_pkg and the RTL of grid_nearest_point_lookup.
`timescale 1ns / 1ps

module grid_nearest_point_lookup_tb;

	localparam int WATCHDOG_LIMIT = 400000;
	localparam int N_PTS  = gnpl_pkg::MAX_POINTS;
	localparam int N_SIDE = gnpl_pkg::MAX_GRID_SIDE;

	typedef struct packed {
		logic        water;
		logic [15:0] elev;
		logic [15:0] pos_y;
		logic [15:0] pos_x;
		logic [1:0]  kind;
	} req_t;

	typedef struct {
		logic [9:0]  idx;
		logic [15:0] elev;
		logic        water;
		logic        empty;
	} hit_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [5:0]  cfg_data;

	grid_nearest_point_lookup i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// predictor state
	logic [15:0] pt_x [N_PTS];
	logic [15:0] pt_y [N_PTS];
	logic [15:0] pt_elev [N_PTS];
	logic        pt_water [N_PTS];
	logic        cell_used [N_SIDE*N_SIDE];
	int          cell_pt [N_SIDE*N_SIDE];
	int          n_points;
	logic [5:0]  side_reg;

	req_t pending_items[$];
	hit_t expected_hits[$];
	int   n_errors;
	int   idle_cycles;
	int   send_idle_pct;
	int   recv_stall_pct;
	logic timed_out;
	logic s_taken;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		n_errors++;
	endtask

	function automatic int side_eff();
		if (side_reg == 0)
			return 1;
		if (side_reg > N_SIDE)
			return N_SIDE;
		return side_reg;
	endfunction

	function automatic int cell_coord(input logic [15:0] c, input int s);
		int g;
		g = (int'(c) * s) >>> 16;
		if (g >= s)
			g = s - 1;
		return g;
	endfunction

	function automatic longint sq_dist(input int i, input logic [15:0] qx,
			input logic [15:0] qy);
		longint dx, dy;
		dx = longint'(pt_x[i]) - longint'(qx);
		dy = longint'(pt_y[i]) - longint'(qy);
		return dx * dx + dy * dy;
	endfunction

	// apply one item to the predictor, queueing a result for queries
	task automatic predict_nearest(input req_t r);
		int s, gx, gy, nx, ny, c, ci, best_i;
		longint d, best;
		bit found;
		hit_t h;
		s = side_eff();
		found = 0;
		best = 0;
		best_i = 0;
		case (r.kind)
			gnpl_pkg::KIND_CLEAR: begin
				foreach (cell_used[k])
					cell_used[k] = 1'b0;
				n_points = 0;
			end
			gnpl_pkg::KIND_LOAD: begin
				if (n_points < N_PTS) begin
					pt_x[n_points] = r.pos_x;
					pt_y[n_points] = r.pos_y;
					pt_elev[n_points] = r.elev;
					pt_water[n_points] = r.water;
					c = cell_coord(r.pos_y, s) * s + cell_coord(r.pos_x, s);
					if (!cell_used[c]) begin
						cell_used[c] = 1'b1;
						cell_pt[c] = n_points;
					end
					n_points++;
				end
			end
			gnpl_pkg::KIND_QUERY: begin
				if (n_points == 0) begin
					h = '{idx: '0, elev: '0, water: 1'b0, empty: 1'b1};
				end else begin
					gx = cell_coord(r.pos_x, s);
					gy = cell_coord(r.pos_y, s);
					for (int dy = -1; dy <= 1; dy++)
						for (int dx = -1; dx <= 1; dx++) begin
							nx = gx + dx;
							ny = gy + dy;
							if (nx >= 0 && ny >= 0 && nx < s && ny < s &&
									cell_used[ny*s+nx]) begin
								ci = cell_pt[ny*s+nx];
								d = sq_dist(ci, r.pos_x, r.pos_y);
								if (!found || d < best) begin
									found = 1;
									best = d;
									best_i = ci;
								end
							end
						end
					if (!found)
						for (int i = 0; i < n_points; i++) begin
							d = sq_dist(i, r.pos_x, r.pos_y);
							if (!found || d < best) begin
								found = 1;
								best = d;
								best_i = i;
							end
						end
					h = '{idx: best_i[9:0], elev: pt_elev[best_i],
						water: pt_water[best_i], empty: 1'b0};
				end
				expected_hits.push_back(h);
			end
			default: ;
		endcase
	endtask

	// driver: item sender, advances only after an accepting edge
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_taken) begin
			if (pending_items.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tuser <= pending_items[0].kind;
				s_tdata <= {7'b0, pending_items[0].water, pending_items[0].elev,
					pending_items[0].pos_y, pending_items[0].pos_x};
				void'(pending_items.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver back-pressure
	always @(negedge clk)
		m_tready <= arst_n && ($urandom_range(99, 0) >= recv_stall_pct);

	// monitor: predicts on input accept, checks on output accept
	always @(posedge clk) begin
		s_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_nearest(req_t'({s_tdata[48:0], s_tuser}));
			if (m_tvalid && m_tready) begin
				if (expected_hits.size() == 0) begin
					report("unexpected result", m_tdata[9:0], 0);
				end else begin
					if (m_tdata[9:0] !== expected_hits[0].idx)
						report("nearest_index", m_tdata[9:0], expected_hits[0].idx);
					if (m_tdata[25:10] !== expected_hits[0].elev)
						report("nearest_elevation", m_tdata[25:10],
							expected_hits[0].elev);
					if (m_tdata[26] !== expected_hits[0].water)
						report("nearest_water", m_tdata[26], expected_hits[0].water);
					if (m_tuser !== expected_hits[0].empty)
						report("no_points", m_tuser, expected_hits[0].empty);
					void'(expected_hits.pop_front());
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
					(cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// watchdog
	always @(posedge clk)
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("[FAIL] regression broken");
			$finish;
		end

	function automatic req_t rand_item(input logic [1:0] k);
		req_t r;
		r.kind = k;
		r.pos_x = 16'($urandom);
		r.pos_y = 16'($urandom);
		r.elev = 16'($urandom);
		r.water = 1'($urandom);
		return r;
	endfunction

	function automatic req_t mk(input logic [1:0] k, input logic [15:0] x,
			input logic [15:0] y, input logic [15:0] e, input logic w);
		req_t r;
		r.kind = k;
		r.pos_x = x;
		r.pos_y = y;
		r.elev = e;
		r.water = w;
		return r;
	endfunction

	// wait for the block to drain, queued clears included, then write the side
	task automatic set_side(input logic [5:0] v);
		while (pending_items.size() > 0 || s_tvalid || expected_hits.size() > 0)
			@(posedge clk);
		repeat (6000) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		side_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int n, input int idle, input int stall);
		int r;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		pending_items.push_back(mk(gnpl_pkg::KIND_CLEAR, 0, 0, 0, 0));
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99, 0);
			if (r < 45)
				pending_items.push_back(rand_item(gnpl_pkg::KIND_LOAD));
			else if (r < 95)
				pending_items.push_back(rand_item(gnpl_pkg::KIND_QUERY));
			else if (r < 97)
				pending_items.push_back(rand_item(gnpl_pkg::KIND_CLEAR));
			else
				pending_items.push_back(rand_item(gnpl_pkg::KIND_IGNORE));
		end
	endtask

	initial begin
		n_errors = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		s_taken = 1'b0;
		side_reg = 6'd1;
		n_points = 0;
		foreach (cell_used[k])
			cell_used[k] = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty store, extremes, ties, ignored kind, side extremes
		pending_items.push_back(mk(gnpl_pkg::KIND_QUERY, 16'hFFFF, 16'hFFFF, 0, 0));
		pending_items.push_back(mk(gnpl_pkg::KIND_LOAD, 0, 0, 16'hFFFF, 1));
		pending_items.push_back(mk(gnpl_pkg::KIND_LOAD, 16'hFFFF, 16'hFFFF, 16'h1234, 0));
		pending_items.push_back(mk(gnpl_pkg::KIND_LOAD, 16'h8000, 16'h8000, 16'h0001, 1));
		pending_items.push_back(mk(gnpl_pkg::KIND_IGNORE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1));
		pending_items.push_back(mk(gnpl_pkg::KIND_QUERY, 0, 0, 0, 0));
		pending_items.push_back(mk(gnpl_pkg::KIND_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1));
		pending_items.push_back(mk(gnpl_pkg::KIND_QUERY, 16'h4000, 16'h4000, 0, 0));
		set_side(6'd32);
		pending_items.push_back(mk(gnpl_pkg::KIND_QUERY, 16'h0100, 16'h0100, 0, 0));
		pending_items.push_back(mk(gnpl_pkg::KIND_CLEAR, 0, 0, 0, 0));
		pending_items.push_back(mk(gnpl_pkg::KIND_QUERY, 16'h0100, 16'h0100, 0, 0));
		pending_items.push_back(mk(gnpl_pkg::KIND_LOAD, 16'h0000, 16'h0000, 16'h00AA, 1));
		pending_items.push_back(mk(gnpl_pkg::KIND_LOAD, 16'hF000, 16'hF000, 16'h00BB, 0));
		pending_items.push_back(mk(gnpl_pkg::KIND_QUERY, 16'h7800, 16'h7800, 0, 0));
		pending_items.push_back(mk(gnpl_pkg::KIND_QUERY, 16'hFFFF, 16'hFFFF, 0, 0));
		set_side(6'd63);
		pending_items.push_back(mk(gnpl_pkg::KIND_QUERY, 16'h0000, 16'h0800, 0, 0));
		set_side(6'd0);
		pending_items.push_back(mk(gnpl_pkg::KIND_QUERY, 16'h0000, 16'h0800, 0, 0));

		// store full: loads past capacity ignored
		set_side(6'd32);
		pending_items.push_back(mk(gnpl_pkg::KIND_CLEAR, 0, 0, 0, 0));
		for (int i = 0; i < N_PTS + 4; i++)
			pending_items.push_back(rand_item(gnpl_pkg::KIND_LOAD));
		for (int i = 0; i < 20; i++)
			pending_items.push_back(rand_item(gnpl_pkg::KIND_QUERY));

		// random phases over side settings and idling patterns
		set_side(6'd4);
		random_phase(80, 0, 0);
		set_side(6'd1);
		random_phase(60, 77, 0);
		set_side(6'd16);
		random_phase(80, 0, 77);
		set_side(6'd32);
		random_phase(60, 21, 21);
		set_side(6'($urandom_range(63, 2)));
		random_phase(50, 0, 0);

		while (pending_items.size() > 0 || s_tvalid || expected_hits.size() > 0)
			@(posedge clk);
		repeat (6000) @(posedge clk);
		if (n_errors == 0 && expected_hits.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
